/* hw/rtl/bcbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcbs_pkg: shared types and constants of the bitmap circular bit search unit
// Field widths, mode codes and the command and hit records that pass between
// the sequencer and the word unit.
// ----------------------------------------------------------------------------
package bcbs_pkg;

   // Fixed field widths of the request, response and register.
   localparam int MODE_W  = 3;
   localparam int IDX_W   = 12;
   localparam int COUNT_W = 13;

   // Value of the entry count register after reset.
   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 13'd4096;

   // Request modes. Codes five to seven are ignored.
   typedef enum logic [MODE_W-1:0] {
      MODE_FIND_SET    = 3'd0,
      MODE_FIND_CLEAR  = 3'd1,
      MODE_FILL_ALL    = 3'd2,
      MODE_FILL_PREFIX = 3'd3,
      MODE_WRITE_BIT   = 3'd4
   } mode_type;

   // Command held by the sequencer while a request is processed.
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [IDX_W-1:0]   start_index;
      logic [IDX_W-1:0]   last_index;
      logic               fill_value;
      logic [COUNT_W-1:0] fill_count;
   } cmd_type;

   // Matches found in one map word, split at the start index.
   typedef struct packed {
      logic             up_hit;
      logic [IDX_W-1:0] up_index;
      logic             lo_hit;
      logic [IDX_W-1:0] lo_index;
   } hit_type;

endpackage

/* hw/rtl/bcbs_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcbs_channels: handshake channels of the bitmap circular bit search unit
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------

// Request channel.
interface bcbs_req_if import bcbs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [IDX_W-1:0]   start_index;
   logic [IDX_W-1:0]   last_index;
   logic               fill_value;
   logic [COUNT_W-1:0] fill_count;

   modport source (output valid, mode, start_index, last_index, fill_value, fill_count,
                   input ready);
   modport sink (input valid, mode, start_index, last_index, fill_value, fill_count,
                 output ready);
endinterface

// Response channel.
interface bcbs_rsp_if import bcbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] found_index;

   modport source (output valid, found, found_index, input ready);
   modport sink (input valid, found, found_index, output ready);
endinterface

// Register write channel for the entry count.
interface bcbs_csr_if import bcbs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, entry_count, input ready);
   modport sink (input valid, entry_count, output ready);
endinterface

/* hw/rtl/bitmap_circular_bit_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_circular_bit_search_unit: circular first-set / first-clear search
// Bitmap of MAP_WORDS words of WORD_BITS bits with search, fill and bit write
// requests, processed one map word per cycle by a shared word unit.
// ----------------------------------------------------------------------------
// Each request walks the whole map once through one read port and one write
// port of the map memory, one word per cycle; when the map holds fewer than
// 4096 entries, a restoring reduction first brings the start and last indexes
// modulo the map size. A finished response waits in an output register while
// the next request is taken. After reset a clearing pass zeroes the map before
// the first request is accepted; entry count writes are taken in any cycle.
module bitmap_circular_bit_search_unit import bcbs_pkg::*; #(
   parameter int WORD_BITS = 64,
   parameter int MAP_WORDS = 64
) (
   input  logic clock,
   input  logic reset,
   bcbs_req_if.sink   req_bus,
   bcbs_rsp_if.source rsp_bus,
   bcbs_csr_if.sink   csr_bus
);

   localparam int TOTAL     = WORD_BITS * MAP_WORDS;
   localparam int BASE_W    = $clog2(TOTAL + 8192) + 1;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
   localparam int RED_STEPS = (TOTAL >= 4096) ? 0 : IDX_W;
   localparam int RED_LAST  = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
   localparam int RED_W     = 4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   cmd_type              cmd_ff, cmd_in;
   logic [RED_W-1:0]     red_step_ff, red_step_in;
   logic [WCNT_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic [BASE_W-1:0]    iss_base_ff, iss_base_in;
   logic                 proc_vld_ff, proc_vld_in;
   logic                 proc_last_ff, proc_last_in;
   logic [AW-1:0]        proc_addr_ff, proc_addr_in;
   logic [BASE_W-1:0]    proc_base_ff, proc_base_in;
   logic                 up_found_ff, up_found_in;
   logic [IDX_W-1:0]     up_index_ff, up_index_in;
   logic                 lo_found_ff, lo_found_in;
   logic [IDX_W-1:0]     lo_index_ff, lo_index_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;

   logic [31:0]          red_cmp;
   logic                 wu_we;
   logic [WORD_BITS-1:0] wu_wdata;
   hit_type              wu_hit;

   // Shared word unit on the word read in the previous cycle.
   bcbs_word_unit #(
      .WORD_BITS (WORD_BITS),
      .BASE_W    (BASE_W)
   ) u_word_unit (
      .word_in     (rd_data_ff),
      .base        (proc_base_ff),
      .cmd         (cmd_ff),
      .entry_count (entry_count_ff),
      .wr_en       (wu_we),
      .wr_data     (wu_wdata),
      .hit         (wu_hit)
   );

   // Handshake outputs.
   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.found_index = rsp_index_ff;

   // Modulo reduction compares against the map size shifted by the step.
   assign red_cmp = 32'(TOTAL) << red_step_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      cmd_in         = cmd_ff;
      red_step_in    = red_step_ff;
      iss_cnt_in     = iss_cnt_ff;
      iss_base_in    = iss_base_ff;
      proc_vld_in    = 1'b0;
      proc_last_in   = proc_last_ff;
      proc_addr_in   = proc_addr_ff;
      proc_base_in   = proc_base_ff;
      up_found_in    = up_found_ff;
      up_index_in    = up_index_ff;
      lo_found_in    = lo_found_ff;
      lo_index_in    = lo_index_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_index_in   = rsp_index_ff;
      entry_count_in = entry_count_ff;
      mem_we         = 1'b0;
      mem_waddr      = proc_addr_ff;
      mem_wdata      = wu_wdata;
      mem_raddr      = iss_cnt_ff[AW-1:0];

      // Register write.
      if (csr_bus.valid) begin
         entry_count_in = csr_bus.entry_count;
      end

      // Response taken by the sink.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in.mode        = req_bus.mode;
               cmd_in.start_index = req_bus.start_index;
               cmd_in.last_index  = req_bus.last_index;
               cmd_in.fill_value  = req_bus.fill_value;
               cmd_in.fill_count  = req_bus.fill_count;
               red_step_in        = RED_W'(RED_LAST);
               iss_cnt_in         = '0;
               iss_base_in        = '0;
               up_found_in        = 1'b0;
               lo_found_in        = 1'b0;
               state_in           = (RED_STEPS > 0) ? ST_REDUCE : ST_SCAN;
            end
         end
         ST_REDUCE: begin
            // One restoring step per cycle on both indexes.
            if ({20'd0, cmd_ff.start_index} >= red_cmp) begin
               cmd_in.start_index = cmd_ff.start_index - red_cmp[IDX_W-1:0];
            end
            if ({20'd0, cmd_ff.last_index} >= red_cmp) begin
               cmd_in.last_index = cmd_ff.last_index - red_cmp[IDX_W-1:0];
            end
            red_step_in = red_step_ff - RED_W'(1);
            if (red_step_ff == '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue the next word read.
            if (iss_cnt_ff < WCNT_W'(MAP_WORDS)) begin
               iss_cnt_in   = iss_cnt_ff + WCNT_W'(1);
               iss_base_in  = iss_base_ff + BASE_W'(WORD_BITS);
               proc_vld_in  = 1'b1;
               proc_addr_in = iss_cnt_ff[AW-1:0];
               proc_base_in = iss_base_ff;
               proc_last_in = (iss_cnt_ff == WCNT_W'(MAP_WORDS - 1));
            end
            // Evaluate the word read last cycle; the first hit is the lowest.
            if (proc_vld_ff) begin
               mem_we = wu_we;
               if (!up_found_ff && wu_hit.up_hit) begin
                  up_found_in = 1'b1;
                  up_index_in = wu_hit.up_index;
               end
               if (!lo_found_ff && wu_hit.lo_hit) begin
                  lo_found_in = 1'b1;
                  lo_index_in = wu_hit.lo_index;
               end
               if (proc_last_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               if (up_found_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_index_in = up_index_ff;
               end else if (lo_found_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_index_in = lo_index_ff;
               end else begin
                  rsp_found_in = 1'b0;
                  rsp_index_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         proc_vld_ff    <= 1'b0;
         up_found_ff    <= 1'b0;
         lo_found_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= ENTRY_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         proc_vld_ff    <= proc_vld_in;
         up_found_ff    <= up_found_in;
         lo_found_ff    <= lo_found_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_count_ff <= entry_count_in;
      end
      cmd_ff       <= cmd_in;
      red_step_ff  <= red_step_in;
      iss_cnt_ff   <= iss_cnt_in;
      iss_base_ff  <= iss_base_in;
      proc_last_ff <= proc_last_in;
      proc_addr_ff <= proc_addr_in;
      proc_base_ff <= proc_base_in;
      up_index_ff  <= up_index_in;
      lo_index_ff  <= lo_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   // Map memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[mem_raddr];
   end

endmodule

/* hw/rtl/bcbs_word_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcbs_word_unit: evaluation of one map word
// Builds the range, entry count and target masks for the word at a given base
// index, finds the lowest match on each side of the start index and forms
// the write-back data for fill and single bit writes.
// ----------------------------------------------------------------------------
module bcbs_word_unit import bcbs_pkg::*; #(
   parameter int WORD_BITS = 64,
   parameter int BASE_W    = 18
) (
   input  logic [WORD_BITS-1:0] word_in,
   input  logic [BASE_W-1:0]    base,
   input  cmd_type              cmd,
   input  logic [COUNT_W-1:0]   entry_count,
   output logic                 wr_en,
   output logic [WORD_BITS-1:0] wr_data,
   output hit_type              hit
);

   localparam int SHIFT_W = $clog2(WORD_BITS);

   // Bits of the word whose entry index is at or above a threshold.
   function automatic logic [WORD_BITS-1:0] ge_mask(input logic [BASE_W-1:0] thr,
                                                    input logic [BASE_W-1:0] at);
      logic signed [BASE_W:0] d;
      logic [WORD_BITS-1:0]   m;
      d = $signed({1'b0, thr}) - $signed({1'b0, at});
      if (d <= 0) begin
         m = '1;
      end else if (d >= $signed((BASE_W+1)'(WORD_BITS))) begin
         m = '0;
      end else begin
         m = {WORD_BITS{1'b1}} << d[SHIFT_W-1:0];
      end
      return m;
   endfunction

   // Position of the lowest set bit.
   function automatic logic [SHIFT_W-1:0] lowest(input logic [WORD_BITS-1:0] x);
      logic [SHIFT_W-1:0] pos;
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (x[b]) begin
            pos = SHIFT_W'(b);
         end
      end
      return pos;
   endfunction

   logic [BASE_W-1:0]    start_ext;
   logic [WORD_BITS-1:0] ge_start;
   logic [WORD_BITS-1:0] ge_after_start;
   logic [WORD_BITS-1:0] ge_after_last;
   logic [WORD_BITS-1:0] below_count;
   logic [WORD_BITS-1:0] in_range;
   logic [WORD_BITS-1:0] target;
   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] up_cand;
   logic [WORD_BITS-1:0] lo_cand;
   logic [WORD_BITS-1:0] fill_word;
   logic                 searching;

   // Threshold masks for this word.
   assign start_ext      = BASE_W'(cmd.start_index);
   assign ge_start       = ge_mask(start_ext, base);
   assign ge_after_start = ge_mask(start_ext + BASE_W'(1), base);
   assign ge_after_last  = ge_mask(BASE_W'(cmd.last_index) + BASE_W'(1), base);
   assign below_count    = ~ge_mask(BASE_W'(entry_count), base);
   assign fill_word      = {WORD_BITS{cmd.fill_value}};

   // Circular window from start to last, inclusive; equal bounds cover all.
   always_comb begin
      if (cmd.start_index == cmd.last_index) begin
         in_range = '1;
      end else if (cmd.start_index < cmd.last_index) begin
         in_range = ge_start & ~ge_after_last;
      end else begin
         in_range = ge_start | ~ge_after_last;
      end
   end

   // Mode decode: search target and write-back.
   always_comb begin
      searching = 1'b0;
      target    = word_in;
      wr_en     = 1'b0;
      wr_data   = word_in;
      case (cmd.mode)
         MODE_FIND_SET: begin
            searching = 1'b1;
            target    = word_in;
         end
         MODE_FIND_CLEAR: begin
            searching = 1'b1;
            target    = ~word_in;
         end
         MODE_FILL_ALL: begin
            wr_en   = 1'b1;
            wr_data = fill_word;
         end
         MODE_FILL_PREFIX: begin
            // A word is covered while its first entry lies below the count.
            wr_en   = base < BASE_W'(cmd.fill_count);
            wr_data = fill_word;
         end
         MODE_WRITE_BIT: begin
            wr_en = |(ge_start & ~ge_after_start);
            if (cmd.fill_value) begin
               wr_data = word_in | (ge_start & ~ge_after_start);
            end else begin
               wr_data = word_in & ~(ge_start & ~ge_after_start);
            end
         end
         default: begin
            searching = 1'b0;
         end
      endcase
   end

   // Matches at or after the start come first, the wrapped part second.
   assign cand    = searching ? (target & in_range & below_count) : '0;
   assign up_cand = cand & ge_start;
   assign lo_cand = cand & ~ge_start;

   assign hit.up_hit   = |up_cand;
   assign hit.up_index = IDX_W'(base + BASE_W'(lowest(up_cand)));
   assign hit.lo_hit   = |lo_cand;
   assign hit.lo_index = IDX_W'(base + BASE_W'(lowest(lo_cand)));

endmodule

/* hw/rtl/bcbs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcbs_checker: port-level checks of the bitmap circular bit search unit
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bcbs_checker import bcbs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input logic [IDX_W-1:0] rsp_found_index
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_found_index))
      else $error("response payload changed while stalled");

   // The unit is busy in the cycle after it takes a request.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request is in progress");

   // The clearing pass keeps requests out right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request ready before the map is cleared");

endmodule

bind bitmap_circular_bit_search_unit bcbs_checker u_bcbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_found       (rsp_bus.found),
   .rsp_found_index (rsp_bus.found_index)
);
